/* hdl/rbtq_pkg.sv */
// Shared types and constants for the ready/blocked task queue block.
// Used by rbtq_ctrl and ready_blocked_task_queues; depends on nothing.
package rbtq_pkg;

  localparam int MAX_TASKS_DEF = 32;
  localparam int MAX_RESULTS   = 32;
  localparam int LIMIT_W       = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd20;

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_BLOCK  = 3'd1,
    MODE_KILL   = 3'd2,
    MODE_WAKE   = 3'd3,
    MODE_LIST   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_READY_FULL    = 3'd1,
    ST_DUP           = 3'd2,
    ST_NOT_FOUND     = 3'd3,
    ST_READY_EMPTY   = 3'd4,
    ST_BLOCKED_EMPTY = 3'd5,
    ST_STORE_FULL    = 3'd6,
    ST_BAD_MODE      = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_ALLOC,
    S_SHIFT,
    S_FIN,
    S_OUT,
    S_LA,
    S_LB,
    S_LC
  } state_t;

  typedef struct packed {
    status_e             status;
    logic [15:0]         pid;
    logic [7:0]          prio;
    logic [15:0]         rsz;
    logic [LIMIT_W-1:0]  total;
    logic                last;
  } res_t;

endpackage

/* hdl/ready_blocked_task_queues.sv */
// Top level of the ready/blocked task queues: limit register, result register
// and the sequencer. Depends on rbtq_pkg and rbtq_ctrl.
//
// Usage: one input beat carries an operation (create, block, kill, wake, list)
// with pid, priority and run size. Each operation returns one result beat,
// except list, which returns one beat per ready task (at most 32), the final
// beat of every item flagged by out_last.
// Timing: in_stall is high while an item is in work. A search reads one queue
// entry per cycle through the order memory port. A refused item goes straight
// to its result; create searches the ready and then the blocked entries. Block,
// kill and wake search their queue, and each entry behind the found task then
// moves up one place per cycle. A list beat is read by the queue read followed
// by the task store read. The sequencer returns to idle after each item before
// it takes the next one.
// Results sit in an output register, so a new item is taken while a result
// waits; when out_stall is high the result beat holds and the sequencer waits.
// cfg_we writes ready_limit (reset value 20); write it only while idle.
// Reset (rst_n low, synchronous) empties both queues and frees every slot.
module ready_blocked_task_queues #(
  parameter int MAX_TASKS = rbtq_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rbtq_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_mode,
  input  logic [15:0]                   in_pid,
  input  logic [7:0]                    in_priority_req,
  input  logic [15:0]                   in_run_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [15:0]                   out_pid,
  output logic [7:0]                    out_priority,
  output logic [15:0]                   out_run_size,
  output logic [rbtq_pkg::LIMIT_W-1:0]  out_ready_total,
  output logic                          out_last
);

  logic [rbtq_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic            out_valid_r, out_valid_nxt;
  rbtq_pkg::res_t  out_r, out_nxt;
  rbtq_pkg::res_t  res;
  logic            res_valid, res_ready;

  rbtq_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .ready_limit (limit_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_pid      (in_pid),
    .in_prio     (in_priority_req),
    .in_rsz      (in_run_size),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  always_comb begin
    limit_nxt = cfg_we ? cfg_wdata : limit_r;
    res_ready = !out_valid_r || !out_stall;
    out_nxt = out_r;
    if (res_valid && res_ready) begin
      out_nxt = res;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= rbtq_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      limit_r <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_pid         = out_r.pid;
  assign out_priority    = out_r.prio;
  assign out_run_size    = out_r.rsz;
  assign out_ready_total = out_r.total;
  assign out_last        = out_r.last;

endmodule

/* hdl/rbtq_ctrl.sv */
// Sequencer for the task queues: slot store, ready and blocked order memories,
// one queue read port shared by search, shift and list. Uses rbtq_pkg.
module rbtq_ctrl #(
  parameter int MAX_TASKS = rbtq_pkg::MAX_TASKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [rbtq_pkg::LIMIT_W-1:0]      ready_limit,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_mode,
  input  logic [15:0]                       in_pid,
  input  logic [7:0]                        in_prio,
  input  logic [15:0]                       in_rsz,
  output logic                              res_valid,
  input  logic                              res_ready,
  output rbtq_pkg::res_t                    res
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int ORD_W  = 16 + SLOT_W;
  localparam int CW     = (CNT_W > rbtq_pkg::LIMIT_W) ? CNT_W : rbtq_pkg::LIMIT_W;
  localparam int UW     = CNT_W + 1;

  rbtq_pkg::state_t state_r, state_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic [15:0]      pid_r, pid_nxt;
  logic [7:0]       prio_r, prio_nxt;
  logic [15:0]      rsz_r, rsz_nxt;
  logic [CNT_W-1:0] rcnt_r, rcnt_nxt, bcnt_r, bcnt_nxt;
  logic [MAX_TASKS-1:0] use_r, use_nxt;
  logic             qsel_r, qsel_nxt;
  logic [CNT_W-1:0] ix_r, ix_nxt, chk_ix_r, chk_ix_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [SLOT_W-1:0] fs_r, fs_nxt;
  logic [ORD_W-1:0] ent_r, ent_nxt;
  logic [CNT_W-1:0] rp_r, rp_nxt, wp_r, wp_nxt, li_r, li_nxt;
  logic             sh_v_r, sh_v_nxt;
  rbtq_pkg::status_e st_r, st_nxt;
  logic [15:0]      opid_r, opid_nxt;
  logic [7:0]       oprio_r, oprio_nxt;
  logic [15:0]      orsz_r, orsz_nxt;
  logic             last_r, last_nxt;

  logic [ORD_W-1:0] ready_mem [MAX_TASKS];
  logic [ORD_W-1:0] blocked_mem [MAX_TASKS];
  logic [23:0]      task_mem [MAX_TASKS];
  logic [ORD_W-1:0] rdr_r, rdb_r;
  logic [23:0]      rdt_r;

  logic [SLOT_W-1:0] q_raddr, t_raddr, rq_waddr, bq_waddr;
  logic              rq_we, bq_we, t_we;
  logic [ORD_W-1:0]  rq_wdata, bq_wdata;

  logic [CNT_W-1:0] n;
  logic [ORD_W-1:0] rdq;
  logic             hit, qend;
  logic [UW-1:0]    used;

  always_comb begin
    n    = qsel_r ? bcnt_r : rcnt_r;
    rdq  = qsel_r ? rdb_r : rdr_r;
    hit  = chk_v_r && (rdq[ORD_W-1:SLOT_W] == pid_r);
    qend = (n == '0) || (chk_v_r && (chk_ix_r + 1'b1 == n));
    used = UW'(rcnt_r) + UW'(bcnt_r);
  end

  always_comb begin
    state_nxt = state_r;  mode_nxt = mode_r;  pid_nxt = pid_r;
    prio_nxt = prio_r;    rsz_nxt = rsz_r;    rcnt_nxt = rcnt_r;
    bcnt_nxt = bcnt_r;    use_nxt = use_r;    qsel_nxt = qsel_r;
    ix_nxt = ix_r;        chk_ix_nxt = chk_ix_r;  chk_v_nxt = chk_v_r;
    fs_nxt = fs_r;        ent_nxt = ent_r;    rp_nxt = rp_r;
    wp_nxt = wp_r;        li_nxt = li_r;      sh_v_nxt = sh_v_r;
    st_nxt = st_r;        opid_nxt = opid_r;  oprio_nxt = oprio_r;
    orsz_nxt = orsz_r;    last_nxt = last_r;
    in_stall = 1'b1;
    res_valid = 1'b0;
    q_raddr = '0;  t_raddr = '0;
    rq_we = 1'b0;  rq_waddr = '0;  rq_wdata = '0;
    bq_we = 1'b0;  bq_waddr = '0;  bq_wdata = '0;
    t_we = 1'b0;

    case (state_r)
      rbtq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          mode_nxt = in_mode;  pid_nxt = in_pid;
          prio_nxt = in_prio;  rsz_nxt = in_rsz;
          ix_nxt = '0;  chk_v_nxt = 1'b0;  fs_nxt = '0;
          opid_nxt = in_pid;  oprio_nxt = '0;  orsz_nxt = '0;
          last_nxt = 1'b1;  st_nxt = rbtq_pkg::ST_OK;
          state_nxt = rbtq_pkg::S_OUT;
          case (in_mode)
            rbtq_pkg::MODE_CREATE: begin
              qsel_nxt = 1'b0;
              if (CW'(rcnt_r) >= CW'(ready_limit)) begin
                st_nxt = rbtq_pkg::ST_READY_FULL;
              end else if (used == UW'(MAX_TASKS)) begin
                st_nxt = rbtq_pkg::ST_STORE_FULL;
              end else begin
                state_nxt = rbtq_pkg::S_FIND;
              end
            end
            rbtq_pkg::MODE_BLOCK, rbtq_pkg::MODE_KILL: begin
              qsel_nxt = 1'b0;
              if (rcnt_r == '0) st_nxt = rbtq_pkg::ST_READY_EMPTY;
              else state_nxt = rbtq_pkg::S_FIND;
            end
            rbtq_pkg::MODE_WAKE: begin
              qsel_nxt = 1'b1;
              if (bcnt_r == '0) st_nxt = rbtq_pkg::ST_BLOCKED_EMPTY;
              else state_nxt = rbtq_pkg::S_FIND;
            end
            rbtq_pkg::MODE_LIST: begin
              li_nxt = '0;
              if (rcnt_r == '0) begin
                st_nxt = rbtq_pkg::ST_READY_EMPTY;
                opid_nxt = '0;
              end else begin
                state_nxt = rbtq_pkg::S_LA;
              end
            end
            default: begin
              st_nxt = rbtq_pkg::ST_BAD_MODE;
              opid_nxt = '0;
            end
          endcase
        end
      end

      rbtq_pkg::S_FIND: begin
        // The free-slot scan runs alongside the pid search of a create.
        if (mode_r == rbtq_pkg::MODE_CREATE && use_r[fs_r]) fs_nxt = fs_r + 1'b1;
        if (hit) begin
          if (mode_r == rbtq_pkg::MODE_CREATE) begin
            st_nxt = rbtq_pkg::ST_DUP;
            state_nxt = rbtq_pkg::S_OUT;
          end else begin
            ent_nxt = rdq;
            rp_nxt = chk_ix_r + 1'b1;
            wp_nxt = chk_ix_r;
            sh_v_nxt = 1'b0;
            state_nxt = rbtq_pkg::S_SHIFT;
          end
        end else if (qend) begin
          if (mode_r == rbtq_pkg::MODE_CREATE && !qsel_r) begin
            qsel_nxt = 1'b1;
            ix_nxt = '0;
            chk_v_nxt = 1'b0;
          end else if (mode_r == rbtq_pkg::MODE_CREATE) begin
            state_nxt = rbtq_pkg::S_ALLOC;
          end else begin
            st_nxt = rbtq_pkg::ST_NOT_FOUND;
            state_nxt = rbtq_pkg::S_OUT;
          end
        end else if (ix_r < n) begin
          q_raddr = ix_r[SLOT_W-1:0];
          ix_nxt = ix_r + 1'b1;
          chk_ix_nxt = ix_r;
          chk_v_nxt = 1'b1;
        end else begin
          chk_v_nxt = 1'b0;
        end
      end

      rbtq_pkg::S_ALLOC: begin
        if (use_r[fs_r]) begin
          fs_nxt = fs_r + 1'b1;
        end else begin
          t_we = 1'b1;
          rq_we = 1'b1;
          rq_waddr = rcnt_r[SLOT_W-1:0];
          rq_wdata = {pid_r, fs_r};
          use_nxt[fs_r] = 1'b1;
          rcnt_nxt = rcnt_r + 1'b1;
          state_nxt = rbtq_pkg::S_OUT;
        end
      end

      rbtq_pkg::S_SHIFT: begin
        // Close the gap: each entry behind the removed one moves up one place.
        if (!sh_v_r && rp_r >= n) begin
          state_nxt = rbtq_pkg::S_FIN;
        end else begin
          if (sh_v_r) begin
            if (qsel_r) begin
              bq_we = 1'b1;  bq_waddr = wp_r[SLOT_W-1:0];  bq_wdata = rdq;
            end else begin
              rq_we = 1'b1;  rq_waddr = wp_r[SLOT_W-1:0];  rq_wdata = rdq;
            end
            wp_nxt = wp_r + 1'b1;
          end
          if (rp_r < n) begin
            q_raddr = rp_r[SLOT_W-1:0];
            rp_nxt = rp_r + 1'b1;
            sh_v_nxt = 1'b1;
          end else begin
            sh_v_nxt = 1'b0;
          end
        end
      end

      rbtq_pkg::S_FIN: begin
        state_nxt = rbtq_pkg::S_OUT;
        case (mode_r)
          rbtq_pkg::MODE_BLOCK: begin
            rcnt_nxt = rcnt_r - 1'b1;
            bq_we = 1'b1;  bq_waddr = bcnt_r[SLOT_W-1:0];  bq_wdata = ent_r;
            bcnt_nxt = bcnt_r + 1'b1;
          end
          rbtq_pkg::MODE_KILL: begin
            rcnt_nxt = rcnt_r - 1'b1;
            use_nxt[ent_r[SLOT_W-1:0]] = 1'b0;
          end
          default: begin
            bcnt_nxt = bcnt_r - 1'b1;
            rq_we = 1'b1;  rq_waddr = rcnt_r[SLOT_W-1:0];  rq_wdata = ent_r;
            rcnt_nxt = rcnt_r + 1'b1;
          end
        endcase
      end

      rbtq_pkg::S_LA: begin
        q_raddr = li_r[SLOT_W-1:0];
        state_nxt = rbtq_pkg::S_LB;
      end

      rbtq_pkg::S_LB: begin
        t_raddr = rdr_r[SLOT_W-1:0];
        opid_nxt = rdr_r[ORD_W-1:SLOT_W];
        state_nxt = rbtq_pkg::S_LC;
      end

      rbtq_pkg::S_LC: begin
        st_nxt = rbtq_pkg::ST_OK;
        oprio_nxt = rdt_r[23:16];
        orsz_nxt = rdt_r[15:0];
        last_nxt = (CW'(li_r) + 1'b1 == CW'(rcnt_r)) ||
                   (CW'(li_r) + 1'b1 == CW'(rbtq_pkg::MAX_RESULTS));
        state_nxt = rbtq_pkg::S_OUT;
      end

      rbtq_pkg::S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (last_r) begin
            state_nxt = rbtq_pkg::S_IDLE;
          end else begin
            li_nxt = li_r + 1'b1;
            state_nxt = rbtq_pkg::S_LA;
          end
        end
      end

      default: state_nxt = rbtq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    res.status = st_r;
    res.pid    = opid_r;
    res.prio   = oprio_r;
    res.rsz    = orsz_r;
    res.total  = rbtq_pkg::LIMIT_W'(rcnt_r);
    res.last   = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbtq_pkg::S_IDLE;
      rcnt_r  <= '0;
      bcnt_r  <= '0;
      use_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rcnt_r  <= rcnt_nxt;
      bcnt_r  <= bcnt_nxt;
      use_r   <= use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;   pid_r <= pid_nxt;    prio_r <= prio_nxt;
    rsz_r <= rsz_nxt;     qsel_r <= qsel_nxt;  ix_r <= ix_nxt;
    chk_ix_r <= chk_ix_nxt;  chk_v_r <= chk_v_nxt;  fs_r <= fs_nxt;
    ent_r <= ent_nxt;     rp_r <= rp_nxt;      wp_r <= wp_nxt;
    li_r <= li_nxt;       sh_v_r <= sh_v_nxt;  st_r <= st_nxt;
    opid_r <= opid_nxt;   oprio_r <= oprio_nxt;  orsz_r <= orsz_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (rq_we) ready_mem[rq_waddr] <= rq_wdata;
    if (bq_we) blocked_mem[bq_waddr] <= bq_wdata;
    if (t_we) task_mem[fs_r] <= {prio_r, rsz_r};
    rdr_r <= ready_mem[q_raddr];
    rdb_r <= blocked_mem[q_raddr];
    rdt_r <= task_mem[t_raddr];
  end

endmodule

/* verif/rbtq_checker.sv */
// Checker for the ready/blocked task queue block: models both queues and the
// task store, predicts result beats and compares them. Depends on rbtq_pkg.
`timescale 1ns / 1ps
module rbtq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_pid,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_run_size,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_pid,
  input  logic [7:0]  out_priority,
  input  logic [15:0] out_run_size,
  input  logic [5:0]  out_ready_total,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  localparam int NT = 32;

  logic [15:0] slot_pid [NT];
  logic [7:0]  slot_prio [NT];
  logic [15:0] slot_rsz [NT];
  logic        slot_busy [NT];
  logic [4:0]  rdy_q [$];
  logic [4:0]  blk_q [$];
  logic [5:0]  limit_reg;
  rbtq_pkg::res_t beats_due [$];

  function automatic int find_pid(input logic [4:0] q [$], input logic [15:0] p);
    for (int i = 0; i < q.size(); i++)
      if (slot_pid[q[i]] == p) return i;
    return -1;
  endfunction

  function automatic rbtq_pkg::res_t mk(input rbtq_pkg::status_e s,
                                        input logic [15:0] p,
                                        input logic [7:0] pr, input logic [15:0] r,
                                        input logic l);
    rbtq_pkg::res_t x;
    x.status = s; x.pid = p; x.prio = pr; x.rsz = r;
    x.total = 6'(rdy_q.size()); x.last = l;
    return x;
  endfunction

  task automatic apply_op(input logic [2:0] m, input logic [15:0] p,
                          input logic [7:0] pr, input logic [15:0] r);
    rbtq_pkg::status_e st;
    int fs, pos, n;
    logic [4:0] s;
    st = rbtq_pkg::ST_OK;
    fs = -1;
    case (m)
      rbtq_pkg::MODE_CREATE: begin
        for (int i = NT - 1; i >= 0; i--) if (!slot_busy[i]) fs = i;
        if (rdy_q.size() >= limit_reg) st = rbtq_pkg::ST_READY_FULL;
        else if (fs < 0) st = rbtq_pkg::ST_STORE_FULL;
        else if (find_pid(rdy_q, p) >= 0 || find_pid(blk_q, p) >= 0)
          st = rbtq_pkg::ST_DUP;
        else begin
          slot_busy[fs] = 1'b1; slot_pid[fs] = p;
          slot_prio[fs] = pr; slot_rsz[fs] = r;
          rdy_q.push_back(fs[4:0]);
        end
        beats_due.push_back(mk(st, p, 8'd0, 16'd0, 1'b1));
      end
      rbtq_pkg::MODE_BLOCK, rbtq_pkg::MODE_KILL: begin
        pos = find_pid(rdy_q, p);
        if (rdy_q.size() == 0) st = rbtq_pkg::ST_READY_EMPTY;
        else if (pos < 0) st = rbtq_pkg::ST_NOT_FOUND;
        else begin
          s = rdy_q[pos];
          rdy_q.delete(pos);
          if (m == rbtq_pkg::MODE_BLOCK) blk_q.push_back(s);
          else slot_busy[s] = 1'b0;
        end
        beats_due.push_back(mk(st, p, 8'd0, 16'd0, 1'b1));
      end
      rbtq_pkg::MODE_WAKE: begin
        pos = find_pid(blk_q, p);
        if (blk_q.size() == 0) st = rbtq_pkg::ST_BLOCKED_EMPTY;
        else if (pos < 0) st = rbtq_pkg::ST_NOT_FOUND;
        else begin
          s = blk_q[pos];
          blk_q.delete(pos);
          rdy_q.push_back(s);
        end
        beats_due.push_back(mk(st, p, 8'd0, 16'd0, 1'b1));
      end
      rbtq_pkg::MODE_LIST: begin
        n = rdy_q.size() > rbtq_pkg::MAX_RESULTS ? rbtq_pkg::MAX_RESULTS : rdy_q.size();
        if (n == 0)
          beats_due.push_back(mk(rbtq_pkg::ST_READY_EMPTY, 16'd0, 8'd0, 16'd0, 1'b1));
        for (int i = 0; i < n; i++) begin
          s = rdy_q[i];
          beats_due.push_back(mk(rbtq_pkg::ST_OK, slot_pid[s], slot_prio[s],
                                 slot_rsz[s], i == n - 1));
        end
      end
      default:
        beats_due.push_back(mk(rbtq_pkg::ST_BAD_MODE, 16'd0, 8'd0, 16'd0, 1'b1));
    endcase
  endtask

  always @(posedge clk) begin
    rbtq_pkg::res_t want;
    if (!rst_n) begin
      fail_count <= 0;
      limit_reg = rbtq_pkg::LIMIT_RESET;
      rdy_q.delete(); blk_q.delete(); beats_due.delete();
      for (int i = 0; i < NT; i++) slot_busy[i] = 1'b0;
    end else begin
      // Compare the result beat before this edge's input changes the model.
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time,
                   {out_status, out_pid, out_priority, out_run_size,
                    out_ready_total, out_last});
          fail_count <= fail_count + 1;
        end else begin
          want = beats_due.pop_front();
          if (want.status !== out_status || want.pid !== out_pid ||
              want.prio !== out_priority || want.rsz !== out_run_size ||
              want.total !== out_ready_total || want.last !== out_last) begin
            $display("%0t: mismatch expected st=%0d pid=%h pr=%h rs=%h tot=%0d last=%b",
                     $time, want.status, want.pid, want.prio, want.rsz,
                     want.total, want.last);
            $display("%0t:          actual   st=%0d pid=%h pr=%h rs=%h tot=%0d last=%b",
                     $time, out_status, out_pid, out_priority, out_run_size,
                     out_ready_total, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) limit_reg = cfg_wdata;
      if (in_valid && !in_stall)
        apply_op(in_mode, in_pid, in_priority_req, in_run_size);
    end
    pending <= beats_due.size();
  end
endmodule

/* verif/tb_ready_blocked_task_queues.sv */
// Testbench top for ready_blocked_task_queues: drives operation beats, limit
// writes and receiver stalls; rbtq_checker does the prediction and checking.
`timescale 1ns / 1ps
module tb_ready_blocked_task_queues;

  logic clk, rst_n, cfg_we, in_valid, in_stall, out_valid, out_stall, out_last;
  logic [5:0] cfg_wdata, out_ready_total;
  logic [2:0] in_mode, out_status;
  logic [15:0] in_pid, in_run_size, out_pid, out_run_size;
  logic [7:0] in_priority_req, out_priority;
  int fail_count, pending, idle_cycles;
  bit long_hold;
  logic [15:0] pid_pool [8];

  ready_blocked_task_queues DUT (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_mode, .in_pid,
    .in_priority_req, .in_run_size, .out_valid, .out_stall, .out_status,
    .out_pid, .out_priority, .out_run_size, .out_ready_total, .out_last
  );

  rbtq_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0;
    in_mode = '0; in_pid = '0; in_priority_req = '0; in_run_size = '0;
  end

  // Receiver: random stall pattern, plus one long hold-off on request.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 1500; hold++) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else
        out_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [2:0] m, input logic [15:0] p,
                         input logic [7:0] pr, input logic [15:0] r);
    in_valid <= 1'b1; in_mode <= m; in_pid <= p;
    in_priority_req <= pr; in_run_size <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic rest(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_then_write(input logic [5:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_pid();
    if ($urandom_range(0, 9) < 8) return pid_pool[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  task automatic random_phase(input int n, input int list_weight);
    int burst;
    int m;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        m = $urandom_range(0, 99);
        if (m < 35) m = rbtq_pkg::MODE_CREATE;
        else if (m < 50) m = rbtq_pkg::MODE_BLOCK;
        else if (m < 65) m = rbtq_pkg::MODE_KILL;
        else if (m < 82) m = rbtq_pkg::MODE_WAKE;
        else if (m < 82 + list_weight) m = rbtq_pkg::MODE_LIST;
        else m = $urandom_range(5, 7);
        send_op(3'(m), pick_pid(), 8'($urandom), 16'($urandom));
        burst--; n--;
      end
      if ($urandom_range(0, 2) != 0) rest($urandom_range(1, 40));
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) pid_pool[i] = 16'($urandom);
    pid_pool[0] = 16'h0000; pid_pool[1] = 16'hFFFF;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queues, extremes, refusals and bad modes.
    send_op(rbtq_pkg::MODE_LIST, 16'h0, 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_BLOCK, 16'h1234, 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_KILL, 16'h1234, 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_WAKE, 16'h1234, 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_CREATE, 16'h0000, 8'h00, 16'h0000);
    send_op(rbtq_pkg::MODE_CREATE, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_op(rbtq_pkg::MODE_CREATE, 16'hFFFF, 8'h12, 16'h3456);
    send_op(rbtq_pkg::MODE_BLOCK, 16'h0000, 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_CREATE, 16'h0000, 8'h1, 16'h1);
    send_op(rbtq_pkg::MODE_WAKE, 16'h5555, 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_BLOCK, 16'h7777, 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_KILL, 16'h0000, 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_WAKE, 16'h0000, 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_LIST, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_op(3'd5, 16'hAAAA, 8'hAA, 16'hAAAA);
    send_op(3'd6, 16'h5555, 8'h55, 16'h5555);
    send_op(3'd7, 16'hFFFF, 8'hFF, 16'hFFFF);

    // Limit zero refuses every create.
    drain_then_write(6'd0);
    send_op(rbtq_pkg::MODE_CREATE, 16'h4242, 8'h1, 16'h2);

    // Widest limit: fill the store past 32, list the maximum, then wake beyond limit.
    drain_then_write(6'd63);
    for (int i = 0; i < 33; i++)
      send_op(rbtq_pkg::MODE_CREATE, 16'(16'h100 + i), 8'(i), 16'(16'h8000 + i));
    send_op(rbtq_pkg::MODE_LIST, 16'h0, 8'h0, 16'h0);
    long_hold = 1'b1;
    for (int i = 0; i < 6; i++) send_op(rbtq_pkg::MODE_LIST, 16'h0, 8'h0, 16'h0);
    for (int i = 0; i < 10; i++)
      send_op(rbtq_pkg::MODE_BLOCK, 16'(16'h100 + i), 8'h0, 16'h0);
    drain_then_write(6'd5);
    for (int i = 0; i < 10; i++)
      send_op(rbtq_pkg::MODE_WAKE, 16'(16'h100 + i), 8'h0, 16'h0);
    send_op(rbtq_pkg::MODE_CREATE, 16'h9999, 8'h0, 16'h0);
    for (int i = 0; i < 32; i++)
      send_op(rbtq_pkg::MODE_KILL, 16'(16'h100 + i), 8'h0, 16'h0);

    drain_then_write(6'd1);
    random_phase(20, 8);
    drain_then_write(6'd32);
    random_phase(40, 6);
    drain_then_write(6'd4);
    random_phase(30, 8);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
